>>> design/btg_pkg.sv
// Shared types and constants for the button tap gesture detector.
`timescale 1ns / 1ps

package btg_pkg;

    localparam int OUT_CNT_W   = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int THR_W       = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAP_LENGTH   = 2'd0,
        CFG_DTAP_WINDOW  = 2'd1,
        CFG_STICK_THRESH = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_SINGLE = 3'd1,
        EV_DOWN   = 3'd2,
        EV_DOUBLE = 3'd3,
        EV_UP     = 3'd4
    } gesture_ev_t;

    typedef struct packed {
        gesture_ev_t           code;
        logic [OUT_CNT_W-1:0]  release_len;
        logic [OUT_CNT_W-1:0]  hold_len;
    } gesture_res_t;

    localparam logic [CFG_DATA_W-1:0] TAP_LENGTH_RST   = 16'd6;
    localparam logic [CFG_DATA_W-1:0] DTAP_WINDOW_RST  = 16'd8;
    localparam logic [THR_W-1:0]      STICK_THRESH_RST = 7'd50;

endpackage

>>> design/btg_gesture.sv
// Fire button classifier: press, tap, double tap and release with held length.
`timescale 1ns / 1ps

module btg_gesture #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic                           fire,
    input  logic [btg_pkg::CFG_DATA_W-1:0] tap_length,
    input  logic [btg_pkg::CFG_DATA_W-1:0] double_tap_window,
    output btg_pkg::gesture_res_t          res
);
    import btg_pkg::*;

    localparam int EXT_W = COUNT_WIDTH + OUT_CNT_W;

    logic                   fire_was_down_reg, fire_was_down_next;
    logic                   tap_pending_reg,   tap_pending_next;
    logic [COUNT_WIDTH-1:0] since_tap_reg,     since_tap_next;
    logic [COUNT_WIDTH-1:0] press_cnt_reg,     press_cnt_next;
    logic [COUNT_WIDTH-1:0] held_cnt_reg,      held_cnt_next;

    logic [COUNT_WIDTH-1:0] since_inc;
    logic [COUNT_WIDTH-1:0] press_inc;
    logic                   timed_out;
    logic                   short_press;
    gesture_ev_t            ev;
    logic [COUNT_WIDTH-1:0] rel_cnt;
    logic [EXT_W-1:0]       rel_ext;
    logic [EXT_W-1:0]       hold_ext;

    assign since_inc = (since_tap_reg == '1) ? since_tap_reg : since_tap_reg + 1'b1;
    assign press_inc = (press_cnt_reg == '1) ? press_cnt_reg : press_cnt_reg + 1'b1;

    assign timed_out = tap_pending_reg &&
        ({{OUT_CNT_W{1'b0}}, since_inc} > {{COUNT_WIDTH{1'b0}}, double_tap_window});
    assign short_press =
        ({{OUT_CNT_W{1'b0}}, press_cnt_reg} < {{COUNT_WIDTH{1'b0}}, tap_length});

    always_comb
    begin
        fire_was_down_next = fire;
        tap_pending_next   = tap_pending_reg;
        since_tap_next     = tap_pending_reg ? since_inc : since_tap_reg;
        press_cnt_next     = press_cnt_reg;
        held_cnt_next      = held_cnt_reg;
        ev                 = EV_NONE;
        rel_cnt            = '0;
        if (timed_out)
        begin
            tap_pending_next = 1'b0;
            since_tap_next   = '0;
            ev               = EV_SINGLE;
        end
        else if (fire && !fire_was_down_reg)
        begin
            press_cnt_next = '0;
            ev             = EV_DOWN;
        end
        else if (fire && fire_was_down_reg)
        begin
            held_cnt_next  = press_cnt_reg;
            press_cnt_next = press_inc;
        end
        else if (!fire && fire_was_down_reg)
        begin
            held_cnt_next = '0;
            if (short_press)
            begin
                if (tap_pending_reg)
                begin
                    tap_pending_next = 1'b0;
                    since_tap_next   = '0;
                    ev               = EV_DOUBLE;
                end
                else
                begin
                    tap_pending_next = 1'b1;
                end
            end
            else
            begin
                rel_cnt = press_cnt_reg;
                ev      = EV_UP;
            end
        end
    end

    assign rel_ext  = {{OUT_CNT_W{1'b0}}, rel_cnt};
    assign hold_ext = {{OUT_CNT_W{1'b0}}, held_cnt_next};

    assign res.code        = ev;
    assign res.release_len = rel_ext[OUT_CNT_W-1:0];
    assign res.hold_len    = hold_ext[OUT_CNT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fire_was_down_reg <= 1'b0;
            tap_pending_reg   <= 1'b0;
            since_tap_reg     <= '0;
            press_cnt_reg     <= '0;
            held_cnt_reg      <= '0;
        end
        else if (step)
        begin
            fire_was_down_reg <= fire_was_down_next;
            tap_pending_reg   <= tap_pending_next;
            since_tap_reg     <= since_tap_next;
            press_cnt_reg     <= press_cnt_next;
            held_cnt_reg      <= held_cnt_next;
        end
    end

`ifndef SYNTHESIS
    // idle tap timer stays cleared
    a_since_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !tap_pending_reg |-> (since_tap_reg == '0))
        else $error("tap timer running with no pending tap");

    a_timeout_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && timed_out) |=> (!tap_pending_reg && since_tap_reg == '0))
        else $error("pending tap survived timeout");

    a_down_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (step && ev == EV_DOWN) |=> (press_cnt_reg == '0 && fire_was_down_reg))
        else $error("press counter not restarted on fire down");

    a_rel_only_up: assert property (@(posedge clk) disable iff (!rst_n)
        (rel_cnt != '0) |-> (ev == EV_UP))
        else $error("release length without fire up");
`endif

endmodule

>>> design/button_tap_gesture_detector.sv
// Each input transfer loads its result into the output register.
// Throughput: one item per cycle while out_ready is high or the output is empty.
// Timing is set by the counter compare and update path of the fire classifier.
// Reset: counters, tap state and output valid clear; config takes 6, 8 and 50.
// Config writes are taken in any cycle; index 3 is ignored.
`timescale 1ns / 1ps

module button_tap_gesture_detector #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [btg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [btg_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     buttons,
    input  logic signed [7:0]              pov_x,
    input  logic signed [7:0]              pov_y,
    input  logic signed [7:0]              stick_x,
    input  logic signed [7:0]              stick_y,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     button_mask,
    output logic [7:0]                     direction_mask,
    output logic [2:0]                     event_code,
    output logic [btg_pkg::OUT_CNT_W-1:0]  release_length,
    output logic [btg_pkg::OUT_CNT_W-1:0]  hold_length,
    output logic signed [7:0]              dead_x,
    output logic signed [7:0]              dead_y
);
    import btg_pkg::*;

    logic [CFG_DATA_W-1:0] tap_length_reg;
    logic [CFG_DATA_W-1:0] dtap_window_reg;
    logic [THR_W-1:0]      thresh_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            btn_reg;
    logic [7:0]            dir_reg, dir_next;
    gesture_res_t          res_reg, res;
    logic signed [7:0]     dead_x_reg, dead_x_next;
    logic signed [7:0]     dead_y_reg, dead_y_next;

    logic                  accept;
    logic signed [8:0]     thr_pos, thr_neg;
    logic signed [8:0]     sx9, sy9;
    logic [8:0]            mag_x, mag_y;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_length_reg  <= TAP_LENGTH_RST;
            dtap_window_reg <= DTAP_WINDOW_RST;
            thresh_reg      <= STICK_THRESH_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_TAP_LENGTH:   tap_length_reg  <= cfg_data;
                CFG_DTAP_WINDOW:  dtap_window_reg <= cfg_data;
                CFG_STICK_THRESH: thresh_reg      <= cfg_data[THR_W-1:0];
                default:          ;
            endcase
        end
    end

    btg_gesture #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_gesture (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (accept),
        .fire              (buttons[0]),
        .tap_length        (tap_length_reg),
        .double_tap_window (dtap_window_reg),
        .res               (res)
    );

    assign thr_pos = signed'({2'b00, thresh_reg});
    assign thr_neg = -thr_pos;
    assign sx9     = 9'(stick_x);
    assign sy9     = 9'(stick_y);
    assign mag_x   = sx9[8] ? 9'(-sx9) : 9'(sx9);
    assign mag_y   = sy9[8] ? 9'(-sy9) : 9'(sy9);

    always_comb
    begin
        dir_next[0] = pov_x < 8'sd0;
        dir_next[1] = pov_x > 8'sd0;
        dir_next[2] = pov_y < 8'sd0;
        dir_next[3] = pov_y > 8'sd0;
        dir_next[4] = sy9 < thr_neg;
        dir_next[5] = sy9 > thr_pos;
        dir_next[6] = sx9 < thr_neg;
        dir_next[7] = sx9 > thr_pos;
        dead_x_next = (mag_x < {2'b00, thresh_reg}) ? 8'sd0 : stick_x;
        dead_y_next = (mag_y < {2'b00, thresh_reg}) ? 8'sd0 : stick_y;
    end

    assign out_valid_next = accept || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            btn_reg    <= buttons;
            dir_reg    <= dir_next;
            res_reg    <= res;
            dead_x_reg <= dead_x_next;
            dead_y_reg <= dead_y_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign button_mask    = btn_reg;
    assign direction_mask = dir_reg;
    assign event_code     = res_reg.code;
    assign release_length = res_reg.release_len;
    assign hold_length    = res_reg.hold_len;
    assign dead_x         = dead_x_reg;
    assign dead_y         = dead_y_reg;

endmodule
